[rtl/scmf_pkg.sv]
// scmf_pkg: item types, op codes, states and constants for the stick
// calibrate / map / filter block. No dependencies.
`default_nettype none
package scmf_pkg;

  localparam int SampleBits = 12;
  localparam int SumBits    = 22;
  localparam int CountBits  = 11;
  localparam int SmoothBits = 20;
  localparam int AccBits    = 29;
  localparam int DivBits    = 22;

  localparam logic [SampleBits-1:0] SampleMax   = 12'd4095;
  localparam logic [SumBits-1:0]    SumMax      = 22'h3FFFFF;
  localparam logic [CountBits-1:0]  MaxCentre   = 11'd1024;
  localparam logic [SmoothBits-1:0] SmoothReset = 20'd384000;
  localparam logic [8:0]            AlphaReset  = 9'd102;
  localparam logic [8:0]            AlphaOne    = 9'd256;

  typedef enum logic [2:0] {
    OP_STICK   = 3'd0,
    OP_RANGE   = 3'd1,
    OP_CENTRE  = 3'd2,
    OP_START   = 3'd3,
    OP_FINISH  = 3'd4,
    OP_SWITCH  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  channel;
    logic [11:0] raw_sample;
    logic [4:0]  switch_bits;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  out_channel;
    logic [10:0] channel_value;
    logic        last;
  } out_item_t;

  // pulse value of one switch channel, idx 0..3
  function automatic logic [11:0] switch_value(input logic [4:0] sw, input logic [1:0] idx);
    logic [11:0] v;
    v = 12'd1500;
    case (idx)
      2'd0: v = sw[0] ? 12'd2000 : 12'd1000;
      2'd1: v = sw[1] ? 12'd1000 : 12'd2000;
      2'd2: begin
        if (!sw[2] && sw[3]) v = 12'd1000;
        else if (sw[2] && !sw[3]) v = 12'd2000;
        else v = 12'd1500;
      end
      default: v = sw[4] ? 12'd2000 : 12'd1000;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/stick_calibrate_map_filter.sv]
// stick_calibrate_map_filter: calibration, piecewise linear map and Q8 smoothing.
// Depends on scmf_pkg.
`default_nettype none
// One item at a time. Calibration ops (range, centre, start) and unused op
// codes emit no result. A stick sample is decoded, runs through the bit-serial
// divider (skipped when the span is zero) and the bit-serial filter multiplier,
// and the result is then loaded. A switch item runs the filter four times and
// emits four results. Finish cal runs the divider once per stick.
// The result register lets the next item in while a result waits.
module stick_calibrate_map_filter (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   sample_valid,
  output logic                  sample_stall,
  input  scmf_pkg::in_item_t    sample,
  output logic                  result_valid,
  input  wire                   result_stall,
  output scmf_pkg::out_item_t   result,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [8:0]            cfg_data
);
  import scmf_pkg::*;

  state_t state, state_next;

  logic [8:0]            alpha;
  logic [SampleBits-1:0] range_low [4];
  logic [SampleBits-1:0] range_high [4];
  logic [SampleBits-1:0] centre_point [4];
  logic [SumBits-1:0]    centre_sum [4];
  logic [CountBits-1:0]  centre_count;
  logic [SmoothBits-1:0] smoothed [8];

  logic [2:0]  chan_k;
  logic        is_switch;
  logic [4:0]  sw_bits;
  logic        div_fin;
  logic [1:0]  fin_idx;
  logic        neg;
  logic        base_hi;
  logic [DivBits-1:0]    dq;
  logic [SampleBits-1:0] rem;
  logic [SampleBits-1:0] divisor;
  logic [4:0]  div_cnt;
  logic [8:0]  mul_a, mul_b;
  logic [AccBits-1:0] mc1, mc2, acc;
  logic [3:0]  mul_cnt;

  logic accept;
  assign accept = (state == ST_IDLE) && sample_valid;

  // stick decode
  logic [SampleBits-1:0] lo, ce, hi, raw;
  logic                  below;
  logic [12:0]           num, den;
  logic [11:0]           num_mag, den_mag;
  logic [DivBits-1:0]    prod;
  always_comb begin
    raw     = sample.raw_sample;
    lo      = range_low[sample.channel];
    ce      = centre_point[sample.channel];
    hi      = range_high[sample.channel];
    below   = raw < ce;
    num     = below ? ({1'b0, raw} - {1'b0, lo}) : ({1'b0, raw} - {1'b0, ce});
    den     = below ? ({1'b0, ce} - {1'b0, lo}) : ({1'b0, hi} - {1'b0, ce});
    num_mag = num[12] ? 12'(-num) : num[11:0];
    den_mag = den[12] ? 12'(-den) : den[11:0];
    // times 500 = 512 - 8 - 4
    prod    = {1'b0, num_mag, 9'b0} - {7'b0, num_mag, 3'b0} - {8'b0, num_mag, 2'b0};
  end

  // one restoring division step
  logic [12:0]           rs;
  logic                  ge;
  logic [SampleBits-1:0] rem_n;
  logic [DivBits-1:0]    q_n;
  logic                  div_last;
  always_comb begin
    rs       = {rem, dq[DivBits-1]};
    ge       = rs >= {1'b0, divisor};
    rem_n    = ge ? 12'(rs - {1'b0, divisor}) : rs[11:0];
    q_n      = {dq[DivBits-2:0], ge};
    div_last = div_cnt == 5'(DivBits - 1);
  end

  // signed map result from the quotient
  logic signed [23:0] sq, m_s;
  logic [11:0]        m_div;
  always_comb begin
    sq  = signed'({2'b0, q_n});
    m_s = (base_hi ? 24'sd1500 : 24'sd1000) + (neg ? -sq : sq);
    if (m_s < 0) m_div = 12'd0;
    else if (m_s > 24'sd3000) m_div = 12'd3000;
    else m_div = m_s[11:0];
  end

  // filter output
  logic [SmoothBits-1:0] snew;
  logic [20:0]           rnd;
  logic [10:0]           v_out;
  logic                  out_free;
  always_comb begin
    snew = acc[27:8];
    rnd  = {1'b0, snew} + 21'd128;
    if (rnd[20:8] < 13'd1000) v_out = 11'd1000;
    else if (rnd[20:8] > 13'd2000) v_out = 11'd2000;
    else v_out = rnd[18:8];
    out_free = !result_valid || !result_stall;
  end

  // where the filter or the divider is started from
  logic        mul_go, div_go;
  logic [11:0] m_start;
  logic [2:0]  k_start;
  logic [DivBits-1:0]    dvd_start;
  logic [SampleBits-1:0] dvs_start;
  always_comb begin
    mul_go    = 1'b0;
    div_go    = 1'b0;
    m_start   = 12'd1500;
    k_start   = chan_k;
    dvd_start = prod;
    dvs_start = den_mag;
    unique case (state)
      ST_IDLE: begin
        if (accept && sample.op == OP_STICK) begin
          k_start = {1'b0, sample.channel};
          if (den == 13'd0) mul_go = 1'b1;
          else div_go = 1'b1;
        end else if (accept && sample.op == OP_SWITCH) begin
          mul_go  = 1'b1;
          k_start = 3'd4;
          m_start = switch_value(sample.switch_bits, 2'd0);
        end else if (accept && sample.op == OP_FINISH && centre_count != '0) begin
          div_go    = 1'b1;
          dvd_start = centre_sum[0];
          dvs_start = 12'(centre_count);
        end
      end
      ST_DIV: begin
        if (div_last && !div_fin) begin
          mul_go  = 1'b1;
          m_start = m_div;
        end else if (div_last && fin_idx != 2'd3) begin
          div_go    = 1'b1;
          dvd_start = centre_sum[fin_idx + 2'd1];
          dvs_start = 12'(centre_count);
        end
      end
      ST_MUL: ;
      ST_OUT: begin
        if (out_free && is_switch && chan_k != 3'd7) begin
          mul_go  = 1'b1;
          k_start = chan_k + 3'd1;
          m_start = switch_value(sw_bits, chan_k[1:0] + 2'd1);
        end
      end
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (div_go) state_next = ST_DIV;
        else if (mul_go) state_next = ST_MUL;
      end
      ST_DIV: begin
        if (mul_go) state_next = ST_MUL;
        else if (div_last && !div_go) state_next = ST_IDLE;
      end
      ST_MUL: if (mul_cnt == 4'd8) state_next = ST_OUT;
      ST_OUT: begin
        if (mul_go) state_next = ST_MUL;
        else if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    sample_stall = state != ST_IDLE;
    cfg_ready    = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      alpha        <= AlphaReset;
      centre_count <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        range_low[i]    <= '0;
        range_high[i]   <= SampleMax;
        centre_point[i] <= 12'd2048;
        centre_sum[i]   <= '0;
      end
      for (int i = 0; i < 8; i++) smoothed[i] <= SmoothReset;
    end else begin
      state <= state_next;
      if (cfg_valid) alpha <= cfg_data;

      if (accept) begin
        unique case (sample.op)
          OP_RANGE: begin
            if (raw > hi) range_high[sample.channel] <= raw;
            if (raw < lo) range_low[sample.channel] <= raw;
          end
          OP_CENTRE: begin
            if (sample.channel != 2'd0 || centre_count < MaxCentre) begin
              if (sample.channel == 2'd0) centre_count <= centre_count + 11'd1;
              if ({1'b0, centre_sum[sample.channel]} + 23'(raw) > {1'b0, SumMax})
                centre_sum[sample.channel] <= SumMax;
              else
                centre_sum[sample.channel] <= centre_sum[sample.channel] + 22'(raw);
            end
          end
          OP_START: begin
            for (int i = 0; i < 4; i++) begin
              range_low[i]  <= SampleMax;
              range_high[i] <= '0;
              centre_sum[i] <= '0;
            end
            centre_count <= '0;
          end
          default: ;
        endcase
        is_switch <= sample.op == OP_SWITCH;
        sw_bits   <= sample.switch_bits;
        div_fin   <= sample.op == OP_FINISH;
        fin_idx   <= 2'd0;
        neg       <= num[12] ^ den[12];
        base_hi   <= !below;
      end

      if (div_go) begin
        dq      <= dvd_start;
        divisor <= dvs_start;
        rem     <= '0;
        div_cnt <= '0;
      end else if (state == ST_DIV) begin
        rem     <= rem_n;
        dq      <= q_n;
        div_cnt <= div_cnt + 5'd1;
      end
      if (state == ST_DIV && div_last && div_fin) begin
        centre_point[fin_idx] <= (q_n > DivBits'(SampleMax)) ? SampleMax : q_n[11:0];
        fin_idx <= fin_idx + 2'd1;
      end

      if (mul_go || div_go) chan_k <= k_start;

      if (state == ST_MUL) begin
        acc     <= acc + (mul_a[0] ? mc1 : '0) + (mul_b[0] ? mc2 : '0);
        mul_a   <= mul_a >> 1;
        mul_b   <= mul_b >> 1;
        mc1     <= mc1 << 1;
        mc2     <= mc2 << 1;
        mul_cnt <= mul_cnt + 4'd1;
      end
      if (mul_go) begin
        acc     <= AccBits'(128);
        mc1     <= {9'b0, m_start, 8'b0};
        mc2     <= {9'b0, smoothed[k_start]};
        mul_a   <= (alpha > AlphaOne) ? AlphaOne : alpha;
        mul_b   <= AlphaOne - ((alpha > AlphaOne) ? AlphaOne : alpha);
        mul_cnt <= '0;
      end

      if (state == ST_OUT && out_free) begin
        result_valid          <= 1'b1;
        result.out_channel    <= chan_k;
        result.channel_value  <= v_out;
        result.last           <= !is_switch || chan_k == 3'd7;
        smoothed[chan_k]      <= snew;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/scmf_checker.sv]
// scmf_checker: port-level checks on the result channel, bound to the top level.
// Depends on scmf_pkg.
`default_nettype none
module scmf_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 result_valid,
  input wire                 result_stall,
  input scmf_pkg::out_item_t result
);
  import scmf_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled item changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.channel_value >= 11'd1000 && result.channel_value <= 11'd2000)
    else $error("value out of range");

  a_stick_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.out_channel[2] |-> result.last)
    else $error("stick item not last");

  a_switch_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.out_channel[2] |-> result.last == (result.out_channel == 3'd7))
    else $error("switch last misplaced");

endmodule

bind stick_calibrate_map_filter scmf_checker u_scmf_checker (
  .clk(clk), .rst(rst), .result_valid(result_valid),
  .result_stall(result_stall), .result(result)
);
`default_nettype wire

[bench/tb_stick_calibrate_map_filter.sv]
// tb_stick_calibrate_map_filter: self-checking bench for the stick conditioner.
// Predicts every result in a small scoreboard class; depends on scmf_pkg and the RTL.
`timescale 1ns / 1ps
module tb_stick_calibrate_map_filter;
  import scmf_pkg::*;

  class channel_scoreboard;
    int unsigned alpha;
    int unsigned lo [4];
    int unsigned hi [4];
    int unsigned mid [4];
    int unsigned sum [4];
    int unsigned count;
    int unsigned filt [8];
    out_item_t pending [$];
    int errors;

    function void clear();
      alpha = AlphaReset;
      for (int i = 0; i < 4; i++) begin
        lo[i] = 0; hi[i] = 4095; mid[i] = 2048; sum[i] = 0;
      end
      count = 0;
      for (int i = 0; i < 8; i++) filt[i] = SmoothReset;
      pending.delete();
      errors = 0;
    endfunction

    function int unsigned smooth(int k, int unsigned m);
      longint unsigned a, acc, v;
      a = (alpha > 256) ? 256 : alpha;
      acc = a * (longint'(m) << 8) + (256 - a) * filt[k] + 128;
      filt[k] = 32'((acc >> 8) & 20'hFFFFF);
      v = (filt[k] + 128) >> 8;
      if (v < 1000) v = 1000;
      if (v > 2000) v = 2000;
      return 32'(v);
    endfunction

    function void note_sample(in_item_t it);
      longint m, x, a, b, base;
      int unsigned v [4];
      int c;
      out_item_t r;
      c = it.channel;
      case (it.op)
        OP_STICK: begin
          x = it.raw_sample;
          if (x < mid[c]) begin a = lo[c]; b = mid[c]; base = 1000; end
          else begin a = mid[c]; b = hi[c]; base = 1500; end
          if (b == a) m = 1500;
          else m = (x - a) * 500 / (b - a) + base;
          if (m < 0) m = 0;
          if (m > 3000) m = 3000;
          r.out_channel = 3'(c);
          r.channel_value = 11'(smooth(c, 32'(m)));
          r.last = 1'b1;
          pending.push_back(r);
        end
        OP_RANGE: begin
          if (it.raw_sample > hi[c]) hi[c] = it.raw_sample;
          if (it.raw_sample < lo[c]) lo[c] = it.raw_sample;
        end
        OP_CENTRE: begin
          if (c != 0 || count < MaxCentre) begin
            if (c == 0) count++;
            sum[c] = (22'h3FFFFF - sum[c] < it.raw_sample) ? 22'h3FFFFF
                     : sum[c] + it.raw_sample;
          end
        end
        OP_START: begin
          for (int i = 0; i < 4; i++) begin lo[i] = 4095; hi[i] = 0; sum[i] = 0; end
          count = 0;
        end
        OP_FINISH: begin
          if (count != 0)
            for (int i = 0; i < 4; i++) mid[i] = (sum[i] / count > 4095) ? 4095 : sum[i] / count;
        end
        OP_SWITCH: begin
          v[0] = it.switch_bits[0] ? 2000 : 1000;
          v[1] = it.switch_bits[1] ? 1000 : 2000;
          if (!it.switch_bits[2] && it.switch_bits[3]) v[2] = 1000;
          else if (it.switch_bits[2] && !it.switch_bits[3]) v[2] = 2000;
          else v[2] = 1500;
          v[3] = it.switch_bits[4] ? 2000 : 1000;
          for (int i = 0; i < 4; i++) begin
            r.out_channel = 3'(4 + i);
            r.channel_value = 11'(smooth(4 + i, v[i]));
            r.last = (i == 3);
            pending.push_back(r);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t w;
      if (pending.size() == 0) begin
        $error("unexpected result ch=%0d value=%0d", got.out_channel, got.channel_value);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.out_channel !== w.out_channel) begin
        $error("out_channel expected %0d actual %0d", w.out_channel, got.out_channel);
        errors++;
      end
      if (got.channel_value !== w.channel_value) begin
        $error("channel_value expected %0d actual %0d", w.channel_value, got.channel_value);
        errors++;
      end
      if (got.last !== w.last) begin
        $error("last expected %0d actual %0d", w.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  in_item_t sample = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  out_item_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [8:0] cfg_data = '0;
  bit rx_quiet = 1'b0;
  int unsigned rx_wait = 0;

  channel_scoreboard board;

  stick_calibrate_map_filter DUT (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: draws a stall length for each item, none while quiet
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        board.check_result(result);
        rx_wait = rx_quiet ? 0 : $urandom_range(0, 5);
      end else if (result_valid && rx_wait != 0) begin
        rx_wait = rx_wait - 1;
      end
      result_stall <= rx_wait != 0;
    end
  end

  // valid stays high after an accept so a zero gap runs back to back
  task automatic send_item(in_item_t it, int gap);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= it;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    board.note_sample(it);
  endtask

  task automatic send(logic [2:0] op, logic [1:0] ch, logic [11:0] raw, logic [4:0] sw);
    in_item_t it;
    it.op = op; it.channel = ch; it.raw_sample = raw; it.switch_bits = sw;
    send_item(it, rx_quiet ? 0 : $urandom_range(0, 5));
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_alpha(logic [8:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    board.alpha = value;
  endtask

  task automatic random_phase(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k < 9) send(OP_STICK, 2'($urandom), 12'($urandom), 5'($urandom));
      else if (k < 13) send(OP_SWITCH, 2'($urandom), 12'($urandom), 5'($urandom));
      else if (k == 13) begin
        // well-formed calibration sequence with random content
        send(OP_START, 2'($urandom), 12'($urandom), 5'($urandom));
        repeat ($urandom_range(1, 6)) send(OP_RANGE, 2'($urandom), 12'($urandom), 5'($urandom));
        repeat ($urandom_range(1, 3))
          for (int c = 0; c < 4; c++)
            send(OP_CENTRE, 2'(c), 12'($urandom_range(1500, 2600)), 5'($urandom));
        send(OP_FINISH, 2'($urandom), 12'($urandom), 5'($urandom));
      end else send(3'($urandom_range(1, 7)), 2'($urandom), 12'($urandom), 5'($urandom));
    end
  endtask

  initial begin
    board = new();
    board.clear();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: switch patterns, reset calibration extremes, unused ops
    send(OP_SWITCH, 2'd0, 12'd0, 5'b00000);
    send(OP_SWITCH, 2'd0, 12'd0, 5'b11111);
    send(OP_SWITCH, 2'd0, 12'd0, 5'b01000);
    send(OP_SWITCH, 2'd0, 12'd0, 5'b00100);
    send(OP_STICK, 2'd0, 12'd0, 5'd0);
    send(OP_STICK, 2'd1, 12'd4095, 5'd0);
    send(OP_STICK, 2'd2, 12'd2048, 5'd0);
    send(3'd6, 2'd3, 12'hFFF, 5'h1F);
    send(3'd7, 2'd0, 12'd0, 5'd0);
    // finish with no centre samples keeps the centres
    send(OP_START, 2'd0, 12'd0, 5'd0);
    send(OP_FINISH, 2'd0, 12'd0, 5'd0);
    // stick sample on the inverted ranges left by start cal, then a short calibration
    send(OP_STICK, 2'd3, 12'd100, 5'd0);
    send(OP_RANGE, 2'd0, 12'd1000, 5'd0);
    send(OP_RANGE, 2'd0, 12'd3000, 5'd0);
    send(OP_CENTRE, 2'd0, 12'd2000, 5'd0);
    send(OP_CENTRE, 2'd1, 12'd4095, 5'd0);
    send(OP_FINISH, 2'd0, 12'd0, 5'd0);
    send(OP_STICK, 2'd0, 12'd1500, 5'd0);
    send(OP_STICK, 2'd0, 12'd4095, 5'd0);
    send(OP_STICK, 2'd0, 12'd0, 5'd0);
    send(OP_STICK, 2'd1, 12'd4095, 5'd0);

    // back to back centre samples with the receiver never stalling
    rx_quiet = 1'b1;
    send(OP_START, 2'd0, 12'd0, 5'd0);
    for (int i = 0; i < 40; i++) send(OP_CENTRE, 2'(i % 4), 12'(1800 + 7 * i), 5'd0);
    send(OP_FINISH, 2'd0, 12'd0, 5'd0);
    send(OP_STICK, 2'd0, 12'd4000, 5'd0);
    rx_quiet = 1'b0;

    // sender holds off until everything is out
    drain();
    write_alpha(9'd256);
    random_phase(25);
    write_alpha(9'd0);
    random_phase(15);
    write_alpha(9'd511);
    random_phase(15);
    write_alpha(9'd257);
    random_phase(10);
    write_alpha(9'($urandom_range(1, 255)));
    random_phase(30);

    drain();
    if (board.errors == 0) $display("** stick_calibrate_map_filter: PASSED **");
    else $display("** stick_calibrate_map_filter: FAILED **");
    $finish;
  end

  initial begin
    #5ms;
    $display("** stick_calibrate_map_filter: FAILED **");
    $finish;
  end
endmodule

[stick_calibrate_map_filter.f]
rtl/scmf_pkg.sv
rtl/stick_calibrate_map_filter.sv
rtl/scmf_checker.sv
bench/tb_stick_calibrate_map_filter.sv
